// File: hdl/jnp_pkg.sv
// Shared types and constants for the JSON nesting prefilter.
package jnp_pkg;

   // Byte codes the front end looks for.
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;

   // Progress through the backslash-u0000 escape.
   localparam logic [2:0] ESC_POS_IDLE = 3'd0;
   localparam logic [2:0] ESC_POS_U    = 3'd1;
   localparam logic [2:0] ESC_POS_LAST = 3'd5;

   localparam logic [3:0] MAX_DEPTH_RESET = 4'd4;
   localparam logic [4:0] DEPTH_CEILING   = 5'd16;

   typedef enum logic [2:0] {
      FAIL_NONE      = 3'd0,
      FAIL_ZERO_BYTE = 3'd1,
      FAIL_NULL_ESC  = 3'd2,
      FAIL_TOO_DEEP  = 3'd3,
      FAIL_STRAY     = 3'd4,
      FAIL_UNCLOSED  = 3'd5
   } fail_reason_type;

   // One classified text byte.
   typedef struct packed {
      logic is_nul;
      logic is_backslash;
      logic is_quote;
      logic is_open;
      logic is_close;
      logic is_lower_u;
      logic is_digit_0;
      logic last;
   } scan_item_type;

   // Handshake toward the downstream side of the queue.
   typedef struct packed {
      logic          valid;
      scan_item_type item;
   } scan_chan_type;

endpackage

// File: hdl/jnp_ifs.sv
// Request and response stream interfaces of the JSON nesting prefilter.
interface jnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jnp_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic [2:0] fail_reason;

   modport source (output valid, output accepted, output fail_reason, input ready);
   modport sink (input valid, input accepted, input fail_reason, output ready);
endinterface

// File: hdl/jnp_front.sv
// Front end: accept request bytes and classify them into scan items.
module jnp_front
   import jnp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   jnp_req_if.sink       req_bus,
   output scan_chan_type front_out,
   input  logic          front_ready
);

   logic          stage_valid_ff;
   logic          stage_valid_in;
   scan_item_type stage_item_ff;
   scan_item_type stage_item_in;
   logic          req_take;

   assign req_bus.ready = !stage_valid_ff || front_ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      stage_item_in.is_nul       = (req_bus.text_byte == CHAR_NUL);
      stage_item_in.is_backslash = (req_bus.text_byte == CHAR_BACKSLASH);
      stage_item_in.is_quote     = (req_bus.text_byte == CHAR_QUOTE);
      stage_item_in.is_open      = (req_bus.text_byte == CHAR_LBRACE) ||
                                   (req_bus.text_byte == CHAR_LBRACKET);
      stage_item_in.is_close     = (req_bus.text_byte == CHAR_RBRACE) ||
                                   (req_bus.text_byte == CHAR_RBRACKET);
      stage_item_in.is_lower_u   = (req_bus.text_byte == CHAR_LOWER_U);
      stage_item_in.is_digit_0   = (req_bus.text_byte == CHAR_DIGIT_0);
      stage_item_in.last         = req_bus.end_of_text;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (front_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff <= stage_item_in;
      end
   end

   assign front_out.valid = stage_valid_ff;
   assign front_out.item  = stage_item_ff;

endmodule

// File: hdl/jnp_queue.sv
// Short queue of scan items between the front end and the scanner.
module jnp_queue
   import jnp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  scan_chan_type push_chan,
   output logic          push_ready,
   output scan_chan_type pop_chan,
   input  logic          pop_ready
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   scan_item_type slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            push;
   logic            pop;

   assign push_ready     = (count_ff != CntFull);
   assign push           = push_chan.valid && push_ready;
   assign pop_chan.valid = (count_ff != '0);
   assign pop_chan.item  = slot_ff[rd_ptr_ff];
   assign pop            = pop_chan.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_chan.item;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count beyond depth");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

// File: hdl/jnp_back.sv
// Scanner: track nesting, strings and escapes, and deliver one verdict per document.
module jnp_back
   import jnp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [3:0]    csr_wr_data,
   input  scan_chan_type scan_chan,
   output logic          scan_ready,
   jnp_rsp_if.source     rsp_bus
);

   logic [3:0]      max_depth_ff;
   logic [4:0]      depth_ff;
   logic [4:0]      depth_in;
   logic            in_string_ff;
   logic            in_string_in;
   logic            after_bs_ff;
   logic            after_bs_in;
   logic [2:0]      esc_pos_ff;
   logic [2:0]      esc_pos_in;
   fail_reason_type error_ff;
   fail_reason_type error_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accepted_ff;
   logic            accepted_in;
   fail_reason_type reason_ff;
   fail_reason_type reason_in;
   logic            pop;
   scan_item_type   it;

   assign it         = scan_chan.item;
   // Hold a finished document back only while the verdict slot is still taken.
   assign scan_ready = !it.last || !rsp_valid_ff || rsp_bus.ready;
   assign pop        = scan_chan.valid && scan_ready;

   always_comb begin
      logic            esc_hit;
      logic [2:0]      esc_next;
      logic [4:0]      depth_inc;
      fail_reason_type verdict;

      depth_in     = depth_ff;
      in_string_in = in_string_ff;
      after_bs_in  = after_bs_ff;
      esc_pos_in   = esc_pos_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      accepted_in  = accepted_ff;
      reason_in    = reason_ff;
      esc_hit      = 1'b0;
      esc_next     = esc_pos_ff;
      depth_inc    = depth_ff + 5'd1;
      verdict      = FAIL_NONE;

      if (pop) begin
         if (error_ff == FAIL_NONE) begin
            if (it.is_nul) begin
               error_in = FAIL_ZERO_BYTE;
            end else begin
               if (esc_pos_ff != ESC_POS_IDLE) begin
                  if ((esc_pos_ff == ESC_POS_U) ? it.is_lower_u : it.is_digit_0) begin
                     if (esc_pos_ff == ESC_POS_LAST) begin
                        esc_hit = 1'b1;
                     end else begin
                        esc_next = esc_pos_ff + 3'd1;
                     end
                  end else begin
                     esc_next = ESC_POS_IDLE;
                  end
               end
               if (esc_hit) begin
                  error_in   = FAIL_NULL_ESC;
                  esc_pos_in = ESC_POS_IDLE;
               end else begin
                  esc_pos_in = esc_next;
                  if (in_string_ff) begin
                     if (after_bs_ff) begin
                        after_bs_in = 1'b0;
                     end else if (it.is_backslash) begin
                        after_bs_in = 1'b1;
                        esc_pos_in  = ESC_POS_U;
                     end else if (it.is_quote) begin
                        in_string_in = 1'b0;
                     end
                  end else if (it.is_quote) begin
                     in_string_in = 1'b1;
                  end else if (it.is_open) begin
                     depth_in = depth_inc;
                     if (depth_inc > {1'b0, max_depth_ff}) begin
                        error_in = FAIL_TOO_DEEP;
                     end
                  end else if (it.is_close) begin
                     if (depth_ff == '0) begin
                        error_in = FAIL_STRAY;
                     end else begin
                        depth_in = depth_ff - 5'd1;
                     end
                  end
               end
            end
         end

         if (it.last) begin
            verdict = error_in;
            if (verdict == FAIL_NONE && (depth_in != '0 || in_string_in)) begin
               verdict = FAIL_UNCLOSED;
            end
            rsp_valid_in = 1'b1;
            accepted_in  = (verdict == FAIL_NONE);
            reason_in    = verdict;
            // Clear everything for the next document.
            depth_in     = '0;
            in_string_in = 1'b0;
            after_bs_in  = 1'b0;
            esc_pos_in   = ESC_POS_IDLE;
            error_in     = FAIL_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff <= MAX_DEPTH_RESET;
         depth_ff     <= '0;
         in_string_ff <= 1'b0;
         after_bs_ff  <= 1'b0;
         esc_pos_ff   <= ESC_POS_IDLE;
         error_ff     <= FAIL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_depth_ff <= csr_wr_data;
         end
         depth_ff     <= depth_in;
         in_string_ff <= in_string_in;
         after_bs_ff  <= after_bs_in;
         esc_pos_ff   <= esc_pos_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      reason_ff   <= reason_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.accepted    = accepted_ff;
   assign rsp_bus.fail_reason = reason_ff;

   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_CEILING)
      else $error("nesting depth past the ceiling");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (error_ff != FAIL_NONE && !(pop && it.last)) |=> (error_ff == $past(error_ff)))
      else $error("first error overwritten inside a document");

   a_esc_pos_range: assert property (@(posedge clock) disable iff (reset)
      esc_pos_ff <= ESC_POS_LAST)
      else $error("escape match position out of range");

   a_verdict_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && it.last))
      else $error("verdict raised without a final byte");

endmodule

// File: hdl/json_nesting_prefilter.sv
// A request byte is classified on the cycle it is taken; a verdict reaches the response once the
// final byte of a document passes the front-end register, a queue slot and the response register.
// Throughput: one byte per cycle while the queue has room and no final byte waits on a verdict
// not yet taken; the queue and the verdict register let the request side keep streaming while a
// verdict waits to be taken. Reset (synchronous, active high) empties the pipeline, clears the
// scan state and sets the depth limit to 4; the block is ready for requests once reset is released.
module json_nesting_prefilter
   import jnp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   jnp_req_if.sink     req_bus,
   jnp_rsp_if.source   rsp_bus
);

   // Classified bytes leave the front end here and enter the queue.
   scan_chan_type front_chan;
   logic          front_ready;
   // Queue head toward the scanner.
   scan_chan_type scan_chan;
   logic          scan_ready;

   // Front end: take a request byte, classify it, and hold it in a register until the queue takes it.
   jnp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .front_out   (front_chan),
      .front_ready (front_ready)
   );

   // Decouple the two sides so a stalled verdict does not stop the request stream at once.
   jnp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_chan  (front_chan),
      .push_ready (front_ready),
      .pop_chan   (scan_chan),
      .pop_ready  (scan_ready)
   );

   // Scanner: advance depth, string and escape state, keep the first error, and
   // drop a verdict into the response register on the last byte of each document.
   jnp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .scan_chan   (scan_chan),
      .scan_ready  (scan_ready),
      .rsp_bus     (rsp_bus)
   );

endmodule
